### hdl/lbnp_pkg.sv
`default_nettype none

package lbnp_pkg;

    localparam int MAX_SRC_W   = 512;
    localparam int MAX_SRC_H   = 512;
    localparam int MAX_DST     = 1024;
    localparam int STORE_DEPTH = MAX_SRC_W * MAX_SRC_H;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int DST_W       = $clog2(MAX_DST);

    localparam int SRC_DIM_W   = 10;
    localparam int DST_SIZE_W  = 11;
    localparam int GAIN_W      = 27;
    localparam int PIXEL_W     = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 27;

    localparam logic [7:0] PAD_BYTE = 8'd114;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_SIZE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALED_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALED_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_GAIN      = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OFFSET,
        ST_SCALE,
        ST_ADDR,
        ST_READ,
        ST_RESULT
    } lbnp_state_t;

    typedef struct packed {
        logic capture;
        logic write_en;
        logic offset_en;
        logic scale_en;
        logic addr_en;
        logic read_en;
        logic out_load;
    } lbnp_ctl_t;

    typedef struct packed {
        logic out_free;
    } lbnp_sts_t;

endpackage

`default_nettype wire

### hdl/lbnp_ifs.sv
`default_nettype none

interface lbnp_req_if;
    import lbnp_pkg::*;

    logic                valid;
    logic                ready;
    logic                cmd;
    logic [STORE_AW-1:0] src_index;
    logic [7:0]          in_blue;
    logic [7:0]          in_green;
    logic [7:0]          in_red;
    logic [DST_W-1:0]    dst_x;
    logic [DST_W-1:0]    dst_y;

    modport source (output valid, cmd, src_index, in_blue, in_green, in_red, dst_x, dst_y,
                    input ready);
    modport sink (input valid, cmd, src_index, in_blue, in_green, in_red, dst_x, dst_y,
                  output ready);
endinterface

interface lbnp_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       from_image;

    modport source (output valid, out_red, out_green, out_blue, from_image, input ready);
    modport sink (input valid, out_red, out_green, out_blue, from_image, output ready);
endinterface

interface lbnp_cfg_if;
    import lbnp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/lbnp_ctrl.sv
`default_nettype none

module lbnp_ctrl (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    req_valid,
    input  wire                    req_cmd,
    output logic                   req_ready,
    input  lbnp_pkg::lbnp_sts_t    sts,
    output lbnp_pkg::lbnp_ctl_t    ctl
);
    import lbnp_pkg::*;

    lbnp_state_t state_reg;
    lbnp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_cmd == CMD_FETCH)
                    begin
                        ctl.capture = 1'b1;
                        state_next  = ST_OFFSET;
                    end
                    else
                    begin
                        ctl.write_en = 1'b1;
                    end
                end
            end
            ST_OFFSET:
            begin
                ctl.offset_en = 1'b1;
                state_next    = ST_SCALE;
            end
            ST_SCALE:
            begin
                ctl.scale_en = 1'b1;
                state_next   = ST_ADDR;
            end
            ST_ADDR:
            begin
                ctl.addr_en = 1'b1;
                state_next  = ST_READ;
            end
            ST_READ:
            begin
                ctl.read_en = 1'b1;
                state_next  = ST_RESULT;
            end
            ST_RESULT:
            begin
                // hold here until the output register can take the result
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/lbnp_datapath.sv
`default_nettype none

module lbnp_datapath (
    input  wire                    clk,
    input  wire                    rst_n,
    lbnp_req_if.sink               req,
    lbnp_rsp_if.source             rsp,
    lbnp_cfg_if.sink               cfg,
    input  lbnp_pkg::lbnp_ctl_t    ctl,
    output lbnp_pkg::lbnp_sts_t    sts
);
    import lbnp_pkg::*;

    // configuration
    logic [SRC_DIM_W-1:0]  src_width_reg;
    logic [SRC_DIM_W-1:0]  src_height_reg;
    logic [DST_SIZE_W-1:0] dst_size_reg;
    logic [DST_SIZE_W-1:0] scaled_width_reg;
    logic [DST_SIZE_W-1:0] scaled_height_reg;
    logic [GAIN_W-1:0]     inv_gain_reg;

    // fetch pipeline
    logic [DST_W-1:0]      x_reg;
    logic [DST_W-1:0]      y_reg;
    logic [10:0]           ox_reg;
    logic [10:0]           oy_reg;
    logic                  in_area_reg;
    logic [21:0]           scaled_x_reg;
    logic [21:0]           scaled_y_reg;
    logic [STORE_AW-1:0]   addr_reg;
    logic [PIXEL_W-1:0]    pix_reg;

    // output register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [7:0]            out_red_reg;
    logic [7:0]            out_green_reg;
    logic [7:0]            out_blue_reg;
    logic                  from_image_reg;

    logic [PIXEL_W-1:0]    frame_mem [STORE_DEPTH];

    logic signed [11:0]    diff_x;
    logic signed [11:0]    diff_y;
    logic signed [11:0]    pad_x;
    logic signed [11:0]    pad_y;
    logic signed [12:0]    ox_full;
    logic signed [12:0]    oy_full;
    logic                  in_area;
    logic [37:0]           prod_x;
    logic [37:0]           prod_y;
    logic [SRC_DIM_W-1:0]  lim_x;
    logic [SRC_DIM_W-1:0]  lim_y;
    logic [SRC_DIM_W-1:0]  sx;
    logic [SRC_DIM_W-1:0]  sy;
    logic [19:0]           row_base;
    logic [20:0]           addr_full;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg     <= 10'd512;
            src_height_reg    <= 10'd512;
            dst_size_reg      <= 11'd640;
            scaled_width_reg  <= 11'd640;
            scaled_height_reg <= 11'd640;
            inv_gain_reg      <= 27'd52429;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SRC_WIDTH:     src_width_reg     <= cfg.data[SRC_DIM_W-1:0];
                REG_SRC_HEIGHT:    src_height_reg    <= cfg.data[SRC_DIM_W-1:0];
                REG_DST_SIZE:      dst_size_reg      <= cfg.data[DST_SIZE_W-1:0];
                REG_SCALED_WIDTH:  scaled_width_reg  <= cfg.data[DST_SIZE_W-1:0];
                REG_SCALED_HEIGHT: scaled_height_reg <= cfg.data[DST_SIZE_W-1:0];
                REG_INV_GAIN:      inv_gain_reg      <= cfg.data[GAIN_W-1:0];
                default:           ;
            endcase
        end
    end

    // frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.write_en)
        begin
            frame_mem[req.src_index] <= {req.in_red, req.in_green, req.in_blue};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.read_en)
        begin
            pix_reg <= frame_mem[addr_reg];
        end
    end

    // letterbox offsets; arithmetic shift gives floor for a negative pad
    always_comb
    begin
        diff_x  = $signed({1'b0, dst_size_reg}) - $signed({1'b0, scaled_width_reg});
        diff_y  = $signed({1'b0, dst_size_reg}) - $signed({1'b0, scaled_height_reg});
        pad_x   = diff_x >>> 1;
        pad_y   = diff_y >>> 1;
        ox_full = $signed({3'b000, x_reg}) - $signed({pad_x[11], pad_x});
        oy_full = $signed({3'b000, y_reg}) - $signed({pad_y[11], pad_y});
        in_area = ({1'b0, x_reg} < dst_size_reg) && ({1'b0, y_reg} < dst_size_reg) &&
                  !ox_full[12] && !oy_full[12] &&
                  (ox_full[11:0] < {1'b0, scaled_width_reg}) &&
                  (oy_full[11:0] < {1'b0, scaled_height_reg});
    end

    assign prod_x = {27'd0, ox_reg} * {11'd0, inv_gain_reg};
    assign prod_y = {27'd0, oy_reg} * {11'd0, inv_gain_reg};

    // clamp to the source edge; zero size clamps to 0
    always_comb
    begin
        lim_x     = (src_width_reg == '0) ? '0 : src_width_reg - 10'd1;
        lim_y     = (src_height_reg == '0) ? '0 : src_height_reg - 10'd1;
        sx        = (scaled_x_reg < {12'd0, lim_x}) ? scaled_x_reg[SRC_DIM_W-1:0] : lim_x;
        sy        = (scaled_y_reg < {12'd0, lim_y}) ? scaled_y_reg[SRC_DIM_W-1:0] : lim_y;
        row_base  = {10'd0, sy} * {10'd0, src_width_reg};
        addr_full = {1'b0, row_base} + {11'd0, sx};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            x_reg <= req.dst_x;
            y_reg <= req.dst_y;
        end
        if (ctl.offset_en)
        begin
            ox_reg      <= ox_full[10:0];
            oy_reg      <= oy_full[10:0];
            in_area_reg <= in_area;
        end
        if (ctl.scale_en)
        begin
            scaled_x_reg <= prod_x[37:16];
            scaled_y_reg <= prod_y[37:16];
        end
        if (ctl.addr_en)
        begin
            addr_reg <= addr_full[STORE_AW-1:0];
        end
        if (ctl.out_load)
        begin
            out_red_reg    <= in_area_reg ? pix_reg[23:16] : PAD_BYTE;
            out_green_reg  <= in_area_reg ? pix_reg[15:8]  : PAD_BYTE;
            out_blue_reg   <= in_area_reg ? pix_reg[7:0]   : PAD_BYTE;
            from_image_reg <= in_area_reg;
        end
    end

    assign sts.out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.out_red    = out_red_reg;
    assign rsp.out_green  = out_green_reg;
    assign rsp.out_blue   = out_blue_reg;
    assign rsp.from_image = from_image_reg;

endmodule

`default_nettype wire

### hdl/letterbox_nearest_pixel_fetch_unit.sv
`default_nettype none

// Channel  Dir  Transaction
// req      in   load (cmd 0: src_index, in_blue/green/red) or fetch (cmd 1: dst_x, dst_y)
// rsp      out  out_red, out_green, out_blue, from_image; one per fetch, none per load
// cfg      in   register write: index, data; always ready
//
// A load writes the frame store at the accepting edge.
// A fetch passes the offset, unsigned Q11.16 scaling multiply, clamp and row-address
// multiply, store read and result steps up to the output register.
// The controller handles one fetch at a time; req is ready again the cycle after
// the result is loaded, while it may still wait in the output register.
// A fetch stalls in its last step while an earlier result is not taken.
// Reset clears control and restores register defaults; the frame store is not cleared.
module letterbox_nearest_pixel_fetch_unit (
    input  wire         clk,
    input  wire         rst_n,
    lbnp_req_if.sink    req,
    lbnp_rsp_if.source  rsp,
    lbnp_cfg_if.sink    cfg
);
    import lbnp_pkg::*;

    lbnp_ctl_t ctl;
    lbnp_sts_t sts;

    lbnp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_cmd   (req.cmd),
        .req_ready (req.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    lbnp_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .ctl   (ctl),
        .sts   (sts)
    );

endmodule

`default_nettype wire
